/* sv/fftri_pkg.sv */
// ----------------------------------------------------------------------------
// fftri_pkg
// Shared types, constants and arithmetic helpers for the force field sampler.
// ----------------------------------------------------------------------------
package fftri_pkg;

   localparam int GRID_MAX    = 16;
   localparam int TABLE_DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int IDX_W       = $clog2(GRID_MAX);
   localparam int GRID_W      = 5;
   localparam int SCALE_W     = 24;
   localparam int POS_W       = 20;
   localparam int FRC_W       = 32;
   localparam int T_W         = 45;
   localparam int FRAC_W      = 29;
   localparam int PROD_W      = 62;
   localparam int CORNERS     = 8;
   localparam int WORD_W      = 3 * FRC_W;

   localparam logic [0:0] OP_LOAD   = 1'b0;
   localparam logic [0:0] OP_SAMPLE = 1'b1;

   localparam logic [1:0] CSR_GRID_POINTS = 2'd0;
   localparam logic [1:0] CSR_CELL_SCALE  = 2'd1;

   localparam logic [GRID_W-1:0]  GRID_RESET  = GRID_W'(16);
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(245760);
   localparam logic signed [POS_W:0] POS_OFFSET = (POS_W+1)'(131072);

   typedef logic signed [FRC_W-1:0]  force_type;
   typedef logic signed [FRAC_W-1:0] frac_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // (v1 - v0) * f, exact
   function automatic prod_type blend_mul(force_type v0, force_type v1, frac_type f);
      logic signed [FRC_W:0] diff;
      diff = {v1[FRC_W-1], v1} - {v0[FRC_W-1], v0};
      return PROD_W'(diff * f);
   endfunction

   // v0 + round(p / 2^16), saturated to 32 bits
   function automatic force_type blend_fin(force_type v0, prod_type p);
      logic signed [PROD_W-1:0] pr;
      logic signed [PROD_W-17:0] sh;
      logic signed [PROD_W-16:0] sum;
      pr  = p + PROD_W'(32768);
      sh  = pr[PROD_W-1:16];
      sum = {sh[PROD_W-17], sh} + (PROD_W-15)'(v0);
      if (sum > (PROD_W-15)'(64'sd2147483647)) begin
         return 32'sh7fffffff;
      end else if (sum < -(PROD_W-15)'(64'sd2147483648)) begin
         return 32'sh80000000;
      end
      return sum[FRC_W-1:0];
   endfunction

endpackage

/* sv/force_field_trilinear_sample.sv */
// A sample request's result is valid once it reaches the last stage register.
// Throughput: one request per cycle unless stalled, set by nine register stages
// fed from eight replicated table copies that each serve one cell corner per
// cycle. Stalls on the result side back up stage by stage; bubbles are squeezed
// out. Reset (synchronous) clears all valid bits and restores the grid and
// scale registers; the force table holds no defined contents until loaded.
// ----------------------------------------------------------------------------
// force_field_trilinear_sample
// Trilinear sampling of a 3D force field table, nine stage pipeline.
// ----------------------------------------------------------------------------
module force_field_trilinear_sample (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [0:0]                        req_operation,
   input  logic [fftri_pkg::ADDR_W-1:0]      req_entry_index,
   input  logic signed [31:0]                req_force_x,
   input  logic signed [31:0]                req_force_y,
   input  logic signed [31:0]                req_force_z,
   input  logic signed [19:0]                req_pos_x,
   input  logic signed [19:0]                req_pos_y,
   input  logic signed [19:0]                req_pos_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_out_force_x,
   output logic signed [31:0]                rsp_out_force_y,
   output logic signed [31:0]                rsp_out_force_z,
   output logic                              rsp_inside_box,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [23:0]                       csr_data
);
   import fftri_pkg::*;

   // configuration
   logic [GRID_W-1:0]  grid_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [GRID_W-1:0]  n_use;
   logic [2*GRID_W-1:0] nn;

   // stage valids and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in, v6_in, v7_in, v8_in, v9_in;
   logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

   // stage 1
   logic [0:0]               op1_ff;
   logic [ADDR_W-1:0]        eidx1_ff;
   force_type                frc1_ff [3];
   logic signed [T_W-1:0]    t1_ff [3];
   logic signed [T_W-1:0]    t1_in [3];

   // stage 2
   logic [0:0]               op2_ff;
   logic [ADDR_W-1:0]        eidx2_ff;
   force_type                frc2_ff [3];
   logic [ADDR_W-1:0]        addr2_ff [CORNERS];
   logic [ADDR_W-1:0]        addr2_in [CORNERS];
   frac_type                 frac2_ff [3];
   frac_type                 frac2_in [3];
   logic                     ok2_ff, ok2_in;
   logic                     wr_en;

   // stage 3
   logic [WORD_W-1:0]        corner3_ff [CORNERS];
   frac_type                 frac3_ff [3];
   logic                     ok3_ff;

   // stage 4 to 9
   prod_type                 zp4_ff [4][3];
   prod_type                 zp4_in [4][3];
   force_type                zl4_ff [4][3];
   force_type                zl4_in [4][3];
   frac_type                 fy4_ff, fx4_ff;
   logic                     ok4_ff;
   force_type                ln5_ff [4][3];
   force_type                ln5_in [4][3];
   frac_type                 fy5_ff, fx5_ff;
   logic                     ok5_ff;
   prod_type                 yp6_ff [2][3];
   prod_type                 yp6_in [2][3];
   force_type                yl6_ff [2][3];
   force_type                yl6_in [2][3];
   frac_type                 fx6_ff;
   logic                     ok6_ff;
   force_type                fc7_ff [2][3];
   force_type                fc7_in [2][3];
   frac_type                 fx7_ff;
   logic                     ok7_ff;
   prod_type                 xp8_ff [3];
   prod_type                 xp8_in [3];
   force_type                xl8_ff [3];
   force_type                xl8_in [3];
   logic                     ok8_ff;
   force_type                res9_ff [3];
   force_type                res9_in [3];
   logic                     ok9_ff;

   logic signed [POS_W-1:0]  pos [3];

   // handshake
   assign en9 = !v9_ff || rsp_ready;
   assign en8 = !v8_ff || en9;
   assign en7 = !v7_ff || en8;
   assign en6 = !v6_ff || en7;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_ready = en1 && !reset;
   assign csr_ready = !reset;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? (v2_ff && op2_ff == OP_SAMPLE) : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;
   assign v5_in = en5 ? v4_ff : v5_ff;
   assign v6_in = en6 ? v5_ff : v6_ff;
   assign v7_in = en7 ? v6_ff : v7_ff;
   assign v8_in = en8 ? v7_ff : v8_ff;
   assign v9_in = en9 ? v8_ff : v9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         v7_ff    <= 1'b0;
         v8_ff    <= 1'b0;
         v9_ff    <= 1'b0;
         grid_ff  <= GRID_RESET;
         scale_ff <= SCALE_RESET;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
         v7_ff <= v7_in;
         v8_ff <= v8_in;
         v9_ff <= v9_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_GRID_POINTS: grid_ff  <= csr_data[GRID_W-1:0];
               CSR_CELL_SCALE:  scale_ff <= csr_data[SCALE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      if (grid_ff < GRID_W'(2)) begin
         n_use = GRID_W'(2);
      end else if (grid_ff > GRID_W'(GRID_MAX)) begin
         n_use = GRID_W'(GRID_MAX);
      end else begin
         n_use = grid_ff;
      end
      nn = (2*GRID_W)'(n_use) * (2*GRID_W)'(n_use);
   end

   // stage 1: map to grid units
   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;

   always_comb begin
      logic signed [POS_W:0]    pe;
      logic signed [T_W:0]      p;
      for (int a = 0; a < 3; a++) begin
         pe = {pos[a][POS_W-1], pos[a]} + POS_OFFSET;
         p  = (T_W+1)'(pe * $signed({1'b0, scale_ff}));
         t1_in[a] = p[T_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff   <= req_operation;
         eidx1_ff <= req_entry_index;
         frc1_ff[0] <= req_force_x;
         frc1_ff[1] <= req_force_y;
         frc1_ff[2] <= req_force_z;
         t1_ff    <= t1_in;
      end
   end

   // stage 2: cell index, fraction, corner addresses
   always_comb begin
      logic signed [T_W-32:0]   c;
      logic signed [T_W-32:0]   cadj;
      logic signed [T_W-32:0]   nm1;
      logic [IDX_W-1:0]         idx [3];
      logic [ADDR_W-1:0]        ax, ay, az;
      nm1   = $signed((T_W-31)'(n_use)) - (T_W-31)'(1);
      ok2_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
         c = (T_W-31)'($signed(t1_ff[a][T_W-1:32]));
         if (c == nm1) begin
            cadj = nm1 - (T_W-31)'(1);
         end else if (c < 0) begin
            cadj = '0;
         end else begin
            cadj = c;
         end
         if (cadj > nm1) begin
            ok2_in = 1'b0;
         end
         idx[a] = cadj[IDX_W-1:0];
         frac2_in[a] = t1_ff[a][T_W-1:16] - $signed({{(FRAC_W-IDX_W-16){1'b0}}, idx[a], 16'd0});
      end
      for (int q = 0; q < CORNERS; q++) begin
         ax = ADDR_W'(idx[0]) + ADDR_W'(q / 4);
         ay = ADDR_W'(idx[1]) + ADDR_W'((q / 2) % 2);
         az = ADDR_W'(idx[2]) + ADDR_W'(q % 2);
         addr2_in[q] = ADDR_W'(ax * ADDR_W'(nn)) + ADDR_W'(ay * ADDR_W'(n_use)) + az;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         op2_ff   <= op1_ff;
         eidx2_ff <= eidx1_ff;
         frc2_ff  <= frc1_ff;
         addr2_ff <= addr2_in;
         frac2_ff <= frac2_in;
         ok2_ff   <= ok2_in;
      end
   end

   // stage 3: table copies, one per corner
   assign wr_en = v2_ff && op2_ff == OP_LOAD && en3;

   for (genvar g = 0; g < CORNERS; g++) begin : g_bank
      logic [WORD_W-1:0] mem [TABLE_DEPTH];
      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[eidx2_ff] <= {frc2_ff[2], frc2_ff[1], frc2_ff[0]};
         end
         if (en3) begin
            corner3_ff[g] <= mem[addr2_ff[g]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         frac3_ff <= frac2_ff;
         ok3_ff   <= ok2_ff;
      end
   end

   // stage 4: blend along z, products
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         for (int k = 0; k < 3; k++) begin
            zl4_in[l][k] = corner3_ff[2*l][FRC_W*k +: FRC_W];
            zp4_in[l][k] = blend_mul(corner3_ff[2*l][FRC_W*k +: FRC_W],
                                     corner3_ff[2*l+1][FRC_W*k +: FRC_W], frac3_ff[2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         zp4_ff <= zp4_in;
         zl4_ff <= zl4_in;
         fy4_ff <= frac3_ff[1];
         fx4_ff <= frac3_ff[0];
         ok4_ff <= ok3_ff;
      end
   end

   // stage 5: lines
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         for (int k = 0; k < 3; k++) begin
            ln5_in[l][k] = blend_fin(zl4_ff[l][k], zp4_ff[l][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         ln5_ff <= ln5_in;
         fy5_ff <= fy4_ff;
         fx5_ff <= fx4_ff;
         ok5_ff <= ok4_ff;
      end
   end

   // stage 6: blend along y, products
   always_comb begin
      for (int f = 0; f < 2; f++) begin
         for (int k = 0; k < 3; k++) begin
            yl6_in[f][k] = ln5_ff[2*f][k];
            yp6_in[f][k] = blend_mul(ln5_ff[2*f][k], ln5_ff[2*f+1][k], fy5_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         yp6_ff <= yp6_in;
         yl6_ff <= yl6_in;
         fx6_ff <= fx5_ff;
         ok6_ff <= ok5_ff;
      end
   end

   // stage 7: faces
   always_comb begin
      for (int f = 0; f < 2; f++) begin
         for (int k = 0; k < 3; k++) begin
            fc7_in[f][k] = blend_fin(yl6_ff[f][k], yp6_ff[f][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         fc7_ff <= fc7_in;
         fx7_ff <= fx6_ff;
         ok7_ff <= ok6_ff;
      end
   end

   // stage 8: blend along x, products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         xl8_in[k] = fc7_ff[0][k];
         xp8_in[k] = blend_mul(fc7_ff[0][k], fc7_ff[1][k], fx7_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en8) begin
         xp8_ff <= xp8_in;
         xl8_ff <= xl8_in;
         ok8_ff <= ok7_ff;
      end
   end

   // stage 9: result register
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         res9_in[k] = ok8_ff ? blend_fin(xl8_ff[k], xp8_ff[k]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en9) begin
         res9_ff <= res9_in;
         ok9_ff  <= ok8_ff;
      end
   end

   assign rsp_valid       = v9_ff;
   assign rsp_out_force_x = res9_ff[0];
   assign rsp_out_force_y = res9_ff[1];
   assign rsp_out_force_z = res9_ff[2];
   assign rsp_inside_box  = ok9_ff;

endmodule

/* sv/fftri_checker.sv */
// ----------------------------------------------------------------------------
// fftri_checker
// Port level checks for the force field sampler, bound to the top level.
// ----------------------------------------------------------------------------
module fftri_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_out_force_x,
   input logic signed [31:0] rsp_out_force_y,
   input logic signed [31:0] rsp_out_force_z,
   input logic               rsp_inside_box,
   input logic               csr_ready
);

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // outside the box the force is zero
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_box |->
         rsp_out_force_x == 0 && rsp_out_force_y == 0 && rsp_out_force_z == 0)
      else $error("nonzero force outside the box");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_force_x)
         && $stable(rsp_inside_box))
      else $error("stalled response changed");

   // register port never back-pressures
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register port not ready");

endmodule

bind force_field_trilinear_sample fftri_checker u_fftri_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_force_x (rsp_out_force_x),
   .rsp_out_force_y (rsp_out_force_y),
   .rsp_out_force_z (rsp_out_force_z),
   .rsp_inside_box  (rsp_inside_box),
   .csr_ready       (csr_ready)
);

/* dv/tb_force_field_trilinear_sample.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_force_field_trilinear_sample
// Checks the force field sampler against its own trilinear predictor. A short
// table of directed requests (wall, extrapolation and outside-box cases) is
// followed by random loads and samples over several grid and scale settings.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_force_field_trilinear_sample;
   import fftri_pkg::*;

   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         DRAIN_CYCLES   = 12;
   localparam int         PHASE_ITEMS    = 170;
   localparam logic [1:0] CSR_UNUSED     = 2'd3;

   typedef struct {
      logic [0:0]         op;
      logic [ADDR_W-1:0]  entry;
      force_type          fx, fy, fz;
      logic signed [19:0] px, py, pz;
   } request_type;

   typedef struct {
      force_type fx, fy, fz;
      logic      in_box;
   } force_sample_type;

   typedef struct {
      request_type      r;
      bit               typed;
      force_sample_type want;
   } dir_row_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [0:0] req_operation;
   logic [ADDR_W-1:0] req_entry_index;
   logic signed [31:0] req_force_x, req_force_y, req_force_z;
   logic signed [19:0] req_pos_x, req_pos_y, req_pos_z;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_out_force_x, rsp_out_force_y, rsp_out_force_z;
   logic rsp_inside_box;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [23:0] csr_data;

   force_field_trilinear_sample u_dut (.*);

   longint           field_mem [TABLE_DEPTH][3];
   bit               loaded [TABLE_DEPTH];
   logic [4:0]       grid_cfg;
   logic [23:0]      scale_cfg;
   force_sample_type pending_samples [$];
   int               errors, n_loads, n_samples, n_in_box, n_settings, idle_cycles;
   bit               calm;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(string what, longint got, longint want);
      if (errors < 30) $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   function automatic int grid_in_use();
      int n;
      n = grid_cfg;
      if (n < 2) n = 2;
      if (n > GRID_MAX) n = GRID_MAX;
      return n;
   endfunction

   function automatic bit map_axis(logic signed [19:0] pos, int n,
                                   output longint idx, output longint frac);
      longint t, c;
      t = (longint'(pos) + 131072) * longint'({40'd0, scale_cfg});
      c = t >>> 32;
      if (c == n - 1) c = n - 2;
      else if (c < 0) c = 0;
      idx = c;
      frac = (t - (c <<< 32)) >>> 16;
      return c <= n - 1;
   endfunction

   function automatic longint mix(longint v0, longint v1, longint f);
      longint s;
      s = v0 + ((((v1 - v0) * f) + 32768) >>> 16);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s;
   endfunction

   function automatic force_sample_type interpolate_force(request_type r);
      force_sample_type res;
      longint ix, iy, iz, fx, fy, fz, e[2][2][2], ln[2][2], fc[2], v[3];
      int n;
      bit ok;
      n = grid_in_use();
      ok = map_axis(r.px, n, ix, fx);
      ok = map_axis(r.py, n, iy, fy) && ok;
      ok = map_axis(r.pz, n, iz, fz) && ok;
      v = '{0, 0, 0};
      if (ok) begin
         for (int c = 0; c < 3; c++) begin
            for (int a = 0; a < 2; a++)
               for (int b = 0; b < 2; b++)
                  for (int d = 0; d < 2; d++)
                     e[a][b][d] = field_mem[(ix+a)*n*n + (iy+b)*n + iz + d][c];
            for (int a = 0; a < 2; a++)
               for (int b = 0; b < 2; b++)
                  ln[a][b] = mix(e[a][b][0], e[a][b][1], fz);
            for (int a = 0; a < 2; a++) fc[a] = mix(ln[a][0], ln[a][1], fy);
            v[c] = mix(fc[0], fc[1], fx);
         end
      end
      res.fx = v[0][31:0];
      res.fy = v[1][31:0];
      res.fz = v[2][31:0];
      res.in_box = ok;
      return res;
   endfunction

   function automatic force_type rand_force();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type load_req(int entry);
      request_type r;
      r = '{default: '0};
      r.op = OP_LOAD;
      r.entry = ADDR_W'(entry);
      r.fx = rand_force();
      r.fy = rand_force();
      r.fz = rand_force();
      return r;
   endfunction

   function automatic request_type sample_req(int x, int y, int z);
      request_type r;
      r = '{default: '0};
      r.op = OP_SAMPLE;
      r.px = 20'(x);
      r.py = 20'(y);
      r.pz = 20'(z);
      return r;
   endfunction

   // position that lands near or inside the grid in use
   function automatic logic signed [19:0] aim_pos();
      longint u, p;
      u = longint'($urandom_range(0, (grid_in_use() + 1) * 65536)) - 65536;
      p = ((u <<< 16) / longint'({40'd0, scale_cfg})) - 131072;
      if ($urandom_range(0, 3) == 0) p += longint'($urandom_range(0, 6)) - 3;
      if (p > 524287) p = 524287;
      if (p < -524288) p = -524288;
      return p[19:0];
   endfunction

   task automatic send_request(request_type r, bit typed = 0,
                               force_sample_type want = '{default: '0});
      int gap;
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= r.op;
      req_entry_index <= r.entry;
      req_force_x     <= r.fx;
      req_force_y     <= r.fy;
      req_force_z     <= r.fz;
      req_pos_x       <= r.px;
      req_pos_y       <= r.py;
      req_pos_z       <= r.pz;
      do @(posedge clock); while (!req_ready);
      if (r.op == OP_LOAD) begin
         field_mem[r.entry] = '{longint'(r.fx), longint'(r.fy), longint'(r.fz)};
         loaded[r.entry] = 1'b1;
         n_loads++;
      end else begin
         n_samples++;
         pending_samples.insert(pending_samples.size(), typed ? want : interpolate_force(r));
      end
   endtask

   // never let a sample read an entry that was not loaded
   task automatic load_corners(request_type r);
      longint ix, iy, iz, f;
      int n, addr;
      n = grid_in_use();
      if (map_axis(r.px, n, ix, f) & map_axis(r.py, n, iy, f) & map_axis(r.pz, n, iz, f))
         for (int a = 0; a < 8; a++) begin
            addr = int'((ix + a[2]) * n * n + (iy + a[1]) * n + iz + a[0]);
            if (!loaded[addr]) send_request(load_req(addr));
         end
   endtask

   task automatic send_sample(request_type r);
      load_corners(r);
      send_request(r);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] data);
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_GRID_POINTS) grid_cfg = data[4:0];
      else if (idx == CSR_CELL_SCALE) scale_cfg = data;
      n_settings++;
   endtask

   // result side
   initial begin
      force_sample_type want;
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected result, box flag", rsp_inside_box, 0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_out_force_x !== want.fx) report_mismatch("force x", rsp_out_force_x, want.fx);
            if (rsp_out_force_y !== want.fy) report_mismatch("force y", rsp_out_force_y, want.fy);
            if (rsp_out_force_z !== want.fz) report_mismatch("force z", rsp_out_force_z, want.fz);
            if (rsp_inside_box !== want.in_box)
               report_mismatch("box flag", rsp_inside_box, want.in_box);
            if (want.in_box) n_in_box++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress, %0d results outstanding", pending_samples.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      dir_row_type      rows [$];
      force_sample_type outside;
      request_type      r;
      int               grids  [7];
      int               scales [7];
      grids  = '{2, 31, 0, 17, 4, 9, 16};
      scales = '{1, 16777215, 65536, 245760, 8388607, 0, 245760};
      reset = 1'b1;
      req_valid = 1'b0; req_operation = '0; req_entry_index = '0;
      req_force_x = '0; req_force_y = '0; req_force_z = '0;
      req_pos_x = '0; req_pos_y = '0; req_pos_z = '0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      errors = 0; n_loads = 0; n_samples = 0; n_in_box = 0; n_settings = 0;
      calm = 1'b0;
      grid_cfg = GRID_RESET;
      scale_cfg = SCALE_RESET;
      outside = '{default: '0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      r = load_req(0);
      r.fx = 32'sh7fffffff; r.fy = 32'sh80000000; r.fz = '0;
      rows.insert(rows.size(), dir_row_type'{r, 0, outside});
      r = load_req(TABLE_DEPTH - 1);
      rows.insert(rows.size(), dir_row_type'{r, 0, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(524287, 524287, 524287), 1, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(524287, 0, 0), 1, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(0, -524288, 524287), 1, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(-524288, -524288, -524288), 0, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(-131072, -131072, -131072), 0, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(0, 0, 0), 0, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(139810, 139810, 139810), 0, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(139810, -524288, 0), 0, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(150732, 150732, 150732), 0, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(150733, 0, 0), 1, outside});
      rows.insert(rows.size(), dir_row_type'{sample_req(-131073, 139809, 65535), 0, outside});
      foreach (rows[i]) begin
         if (rows[i].r.op == OP_SAMPLE) load_corners(rows[i].r);
         send_request(rows[i].r, rows[i].typed, rows[i].want);
      end

      write_csr(CSR_UNUSED, 24'hffffff);
      for (int ph = 0; ph < 7; ph++) begin
         write_csr(CSR_GRID_POINTS, 24'(grids[ph]));
         write_csr(CSR_CELL_SCALE,
                   24'(scales[ph] == 0 ? $urandom_range(1, 24'hffffff) : scales[ph]));
         for (int k = 0; n_loads + n_samples < (ph + 1) * PHASE_ITEMS; k++) begin
            if (k % 20 == 0) calm = ($urandom_range(0, 2) == 0);
            if (ph == 3 && k == 10) begin
               req_valid <= 1'b0;
               while (pending_samples.size() != 0) @(posedge clock);
            end
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4: send_request(load_req($urandom_range(0, TABLE_DEPTH - 1)));
               5, 6, 7: send_sample(sample_req($urandom, $urandom, $urandom));
               default: send_sample(sample_req(aim_pos(), aim_pos(), aim_pos()));
            endcase
         end
      end
      req_valid <= 1'b0;

      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d loads and %0d samples (%0d in the box)",
               n_loads, n_samples, n_in_box);
      $display("over %0d register writes, grid sizes 0 to 31 and scales up to full range",
               n_settings);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/fftri_pkg.sv
sv/force_field_trilinear_sample.sv
sv/fftri_checker.sv
dv/tb_force_field_trilinear_sample.sv
